/* hw/rtl/ecelg_pkg.sv */
// Package for the elliptic-curve ElGamal core: widths, register indexes, states, unit ops.
// No dependencies.
package ecelg_pkg;
  localparam int FIELD_BITS_DEF = 32;
  localparam int CFG_IDX_BITS   = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CURVE_A = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CURVE_P = 1'b1;
  localparam int IN_TDATA_BITS  = 232;
  localparam int OUT_TDATA_BITS = 136;

  typedef enum logic [5:0] {
    S_IDLE,
    S_RED_START,   // reduce one input value (coordinate or curve_a)
    S_RED_WAIT,
    S_RED_NEXT,
    S_PM_INIT,     // scalar multiply setup
    S_PM_DBL,
    S_PM_ADDSEL,
    S_PM_NEXT,
    S_PA_START,    // point add entry
    S_PA_NUM1,
    S_PA_NUM2,
    S_PA_NUM3,
    S_PA_DEN,
    S_INV_START,
    S_INV_DIV,
    S_INV_MULQ,
    S_INV_STEP,
    S_PA_LAM,
    S_PA_X1,
    S_PA_X2,
    S_PA_Y1,
    S_PA_Y2,
    S_PA_DONE,
    S_AFTER_PM,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    U_NONE,
    U_MUL,
    U_DIV
  } unit_op_t;
endpackage

/* hw/rtl/ec_elgamal_encrypt_decrypt_core.sv */
// Top level of the elliptic-curve ElGamal core (encrypt and decrypt).
// Depends on ecelg_pkg.
//
// channel   | direction | contents
// s_axis    | in        | tdata: op, scalar, base_x/y, other_x/y, msg_x/y
// m_axis    | out       | tdata: out1_x/y, out2_x/y, at_infinity
// cfg       | in        | cfg_we, cfg_idx, cfg_data (curve_a, curve_p)
//
// One request runs two scalar multiplies of W double/add steps to encrypt, one to
// decrypt, each point add running an extended Euclid inverse of up to ~46 steps at
// 32 bits (a divide and a multiply per step). Every field multiply and quotient runs
// bit-serially over all W bits in one shared unit; short scalars do not finish sooner.
// Reset returns to idle with curve_a = 1, curve_p = 23. s_axis_tready is high only
// when idle; the result is held on m_axis until taken.
module ec_elgamal_encrypt_decrypt_core #(
  parameter int FIELD_BITS = ecelg_pkg::FIELD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ecelg_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [FIELD_BITS-1:0]                 cfg_data,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // op, scalar, base_x, base_y, other_x, other_y, msg_x, msg_y, zero fill
  input  logic [((1+7*FIELD_BITS+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // out1_x, out1_y, out2_x, out2_y, at_infinity, zero fill
  output logic [((1+4*FIELD_BITS+7)/8)*8-1:0]   m_axis_tdata
);
  import ecelg_pkg::*;

  localparam int W   = FIELD_BITS;
  localparam int CW  = $clog2(W+1);
  localparam int IW  = ((1+7*W+7)/8)*8;
  localparam int OW  = ((1+4*W+7)/8)*8;

  state_t state, state_next;

  logic [W-1:0] reg_a, reg_p;
  logic [W-1:0] p;
  logic [W-1:0] in_k;
  logic         in_op;
  logic [W-1:0] raw [7];
  logic [W-1:0] red [7];
  logic [2:0]   red_i;

  // shared serial unit: mul (x*y mod p) or div (n / d -> q, r)
  unit_op_t     u_op;
  logic [W-1:0] u_x, u_y, u_n, u_d, u_acc, u_q;
  logic [W:0]   u_r;
  logic [CW-1:0] u_cnt;
  logic         u_busy, u_done;

  // point arithmetic registers
  logic [W-1:0] px, py, qx, qy, rx, ry;
  logic         pinf, qinf, rinf;
  logic [W-1:0] num, den, lam, t1v, x3;
  logic [W-1:0] e_r0, e_r1, e_t0, e_t1, e_q;
  logic [W-1:0] pm_k, pm_bx, pm_by;
  logic [CW-1:0] pm_bit;
  logic         pm_dbl;
  logic [1:0]   phase;
  logic [W-1:0] c1x, c1y, c2x, c2y;
  logic         c1inf, c2inf, c2used;
  logic         p_small;

  logic         start_mul, start_div;
  logic [W-1:0] sm_x, sm_y, sd_n, sd_d;

  function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] subm(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] m);
    return (x >= y) ? (x - y) : (x + (m - y));
  endfunction

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a <= W'(1);
      reg_p <= W'(23);
    end else if (cfg_we) begin
      if (cfg_idx == REG_CURVE_A) reg_a <= cfg_data;
      else if (cfg_idx == REG_CURVE_P) reg_p <= cfg_data;
    end
  end

  // serial unit
  always_ff @(posedge clk) begin
    if (rst) begin
      u_busy <= 1'b0;
      u_done <= 1'b0;
    end else begin
      u_done <= 1'b0;
      if (start_mul) begin
        u_op <= U_MUL; u_x <= sm_x; u_y <= sm_y; u_acc <= '0;
        u_cnt <= CW'(W); u_busy <= 1'b1;
      end else if (start_div) begin
        u_op <= U_DIV; u_n <= sd_n; u_d <= sd_d; u_q <= '0; u_r <= '0;
        u_cnt <= CW'(W); u_busy <= 1'b1;
      end else if (u_busy) begin
        if (u_op == U_MUL) begin
          if (u_y[W-1]) u_acc <= addm(addm(u_acc, u_acc, p), u_x, p);
          else          u_acc <= addm(u_acc, u_acc, p);
          u_y <= u_y << 1;
        end else begin
          if ({u_r[W-1:0], u_n[W-1]} >= {1'b0, u_d}) begin
            u_r <= {u_r[W-1:0], u_n[W-1]} - {1'b0, u_d};
            u_q <= {u_q[W-2:0], 1'b1};
          end else begin
            u_r <= {u_r[W-1:0], u_n[W-1]};
            u_q <= {u_q[W-2:0], 1'b0};
          end
          u_n <= u_n << 1;
        end
        u_cnt <= u_cnt - CW'(1);
        if (u_cnt == CW'(1)) begin
          u_busy <= 1'b0;
          u_done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (s_axis_tvalid) state_next = S_RED_START;
      S_RED_START: state_next = p_small ? S_DONE : S_RED_WAIT;
      S_RED_WAIT:  if (u_done) state_next = S_RED_NEXT;
      S_RED_NEXT:  state_next = (red_i == 3'd6) ? S_PM_INIT : S_RED_START;
      S_PM_INIT:   state_next = S_PM_DBL;
      S_PM_DBL:    state_next = S_PA_START;
      S_PM_ADDSEL: state_next = S_PA_START;
      S_PM_NEXT:   state_next = (pm_bit == CW'(1)) ? S_AFTER_PM : S_PM_DBL;
      S_PA_START: begin
        if (pinf || qinf) state_next = S_PA_DONE;
        else if (px == qx && py != qy) state_next = S_PA_DONE;
        else if (px == qx) state_next = S_PA_NUM1;
        else state_next = S_PA_DEN;
      end
      S_PA_NUM1:   if (u_done) state_next = S_PA_NUM2;
      S_PA_NUM2:   if (u_done) state_next = S_PA_NUM3;
      S_PA_NUM3:   state_next = S_PA_DEN;
      S_PA_DEN:    state_next = S_INV_START;
      S_INV_START: state_next = (e_r1 == '0) ? S_PA_LAM : S_INV_DIV;
      S_INV_DIV:   if (u_done) state_next = S_INV_MULQ;
      S_INV_MULQ:  if (u_done) state_next = S_INV_STEP;
      S_INV_STEP:  state_next = S_INV_START;
      S_PA_LAM:    if (e_r0 != W'(1)) state_next = S_PA_DONE;
                   else if (u_done) state_next = S_PA_X1;
      S_PA_X1:     if (u_done) state_next = S_PA_X2;
      S_PA_X2:     state_next = S_PA_Y1;
      S_PA_Y1:     if (u_done) state_next = S_PA_Y2;
      S_PA_Y2:     state_next = S_PA_DONE;
      S_PA_DONE:   state_next = (phase == 2'd2 || phase == 2'd3) ? S_AFTER_PM :
                                 (pm_dbl ? S_PM_ADDSEL : S_PM_NEXT);
      S_AFTER_PM:  state_next = (phase == 2'd2 || phase == 2'd3) ? S_DONE :
                                 ((phase == 2'd1 || in_op) ? S_PA_START : S_PM_INIT);
      S_DONE:      if (m_axis_tready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // unit requests
  always_comb begin
    start_mul = 1'b0; start_div = 1'b0;
    sm_x = '0; sm_y = '0; sd_n = '0; sd_d = p;
    case (state)
      S_RED_START: begin start_div = !p_small; sd_n = raw[red_i]; sd_d = p; end
      S_PA_START:  if (!(pinf || qinf) && px == qx && py == qy) begin
        start_mul = 1'b1; sm_x = px; sm_y = px;
      end
      S_PA_NUM1:   if (u_done) begin
        start_mul = 1'b1; sm_x = u_acc; sm_y = (p == W'(3)) ? '0 : W'(3);
      end
      S_INV_START: if (e_r1 != '0) begin start_div = 1'b1; sd_n = e_r0; sd_d = e_r1; end
      S_INV_DIV:   if (u_done) begin start_mul = 1'b1; sm_x = u_q; sm_y = e_t1; end
      S_PA_LAM:    ;
      S_PA_X1:     ;
      default: ;
    endcase
    if (state == S_INV_START && e_r1 == '0 && e_r0 == W'(1)) begin
      start_mul = 1'b1; sm_x = num; sm_y = e_t0;
    end
    if (state == S_PA_LAM && u_done) begin start_mul = 1'b1; sm_x = u_acc; sm_y = u_acc; end
    if (state == S_PA_X2) begin start_mul = 1'b1; sm_x = lam; sm_y = subm(px, x3, p); end
  end

  assign p_small = (p < W'(3));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      m_axis_tvalid <= (state_next == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (s_axis_tvalid) begin
        in_op <= s_axis_tdata[0];
        in_k  <= s_axis_tdata[1 +: W];
        for (int j = 0; j < 6; j++) raw[j] <= s_axis_tdata[1+W*(j+1) +: W];
        raw[6] <= reg_a;
        p <= reg_p;
        red_i <= '0;
        phase <= 2'd0;
        c1x <= '0; c1y <= '0; c2x <= '0; c2y <= '0;
        c1inf <= 1'b1; c2inf <= 1'b0; c2used <= 1'b0;
      end
      S_RED_WAIT: if (u_done) red[red_i] <= u_r[W-1:0];
      S_RED_NEXT: red_i <= red_i + 3'd1;
      S_PM_INIT: begin
        rinf <= 1'b1; rx <= '0; ry <= '0;
        pm_k <= in_k; pm_bit <= CW'(W);
        pm_bx <= (phase == 2'd0) ? red[0] : red[2];
        pm_by <= (phase == 2'd0) ? red[1] : red[3];
      end
      S_PM_DBL: begin
        px <= rx; py <= ry; pinf <= rinf;
        qx <= rx; qy <= ry; qinf <= rinf;
        pm_dbl <= 1'b1;
      end
      S_PM_ADDSEL: begin
        pm_dbl <= 1'b0;
        px <= rx; py <= ry; pinf <= rinf;
        qx <= pm_bx; qy <= pm_by; qinf <= !pm_k[W-1];
      end
      S_PM_NEXT: begin
        pm_k <= pm_k << 1;
        pm_bit <= pm_bit - CW'(1);
      end
      S_PA_START: begin
        rx <= '0; ry <= '0; rinf <= 1'b1;
        if (pinf) begin rx <= qx; ry <= qy; rinf <= qinf; end
        else if (qinf) begin rx <= px; ry <= py; rinf <= 1'b0; end
        else if (px != qx) begin num <= subm(qy, py, p); den <= subm(qx, px, p); end
        else den <= addm(py, py, p);
      end
      S_PA_NUM2: if (u_done) num <= addm(u_acc, red[6], p);
      S_PA_DEN: begin
        e_r0 <= p; e_r1 <= den; e_t0 <= '0; e_t1 <= W'(1);
      end
      S_INV_DIV: if (u_done) begin e_q <= u_q; t1v <= u_r[W-1:0]; end
      S_INV_STEP: begin
        e_r0 <= e_r1; e_r1 <= t1v;
        e_t0 <= e_t1; e_t1 <= subm(e_t0, u_acc, p);
      end
      S_PA_LAM: if (u_done) lam <= u_acc;
      S_PA_X1:  if (u_done) x3 <= subm(subm(u_acc, px, p), qx, p);
      S_PA_Y1:  if (u_done) begin
        rx <= x3; ry <= subm(u_acc, py, p); rinf <= 1'b0;
      end
      S_AFTER_PM: begin
        case (phase)
          2'd0: begin
            c1x <= rx; c1y <= ry; c1inf <= rinf;
            if (in_op) begin
              px <= red[2]; py <= red[3]; pinf <= 1'b0;
              qx <= rx; qy <= rinf ? ry : subm('0, ry, p); qinf <= rinf;
              phase <= 2'd3;
            end else phase <= 2'd1;
          end
          2'd1: begin
            px <= red[4]; py <= red[5]; pinf <= 1'b0;
            qx <= rx; qy <= ry; qinf <= rinf;
            phase <= 2'd2; c2used <= 1'b1;
          end
          2'd2: begin c2x <= rx; c2y <= ry; c2inf <= rinf; phase <= 2'd3; end
          default: begin
            if (in_op) begin c1x <= rx; c1y <= ry; c1inf <= rinf; end
            else begin c2x <= rx; c2y <= ry; c2inf <= rinf; end
          end
        endcase
      end
      default: ;
    endcase
  end

  // zero coordinates at infinity or of an unused out2; p below three zeroes all
  logic [W-1:0] o1x, o1y, o2x, o2y;
  logic         oinf;
  always_comb begin
    o1x = c1inf ? '0 : c1x;
    o1y = c1inf ? '0 : c1y;
    o2x = (c2inf || !c2used) ? '0 : c2x;
    o2y = (c2inf || !c2used) ? '0 : c2y;
    oinf = c1inf || c2inf;
    if (p_small) begin o1x = '0; o1y = '0; o2x = '0; o2y = '0; oinf = 1'b1; end
  end

  assign m_axis_tdata = OW'({oinf, o2y, o2x, o1y, o1x});

  logic unused_ok;
  assign unused_ok = ^{e_q, IW[0]};
endmodule

/* hw/rtl/ecelg_checker.sv */
// Port-level checker for the ElGamal core, bound to the top level.
// Depends on ec_elgamal_encrypt_decrypt_core.
module ecelg_port_checker #(
  parameter int OW = 136
) (
  input logic          clk,
  input logic          rst,
  input logic          s_axis_tvalid,
  input logic          s_axis_tready,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [OW-1:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready while a result is pending");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind ec_elgamal_encrypt_decrypt_core ecelg_port_checker #(.OW(((1+4*FIELD_BITS+7)/8)*8)) u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
